### hw/rtl/mec_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// Mandelbrot escape-time classifier. No dependencies.
package mec_pkg;

  localparam int FRAC_BITS  = 28;
  localparam int COUNT_BITS = 10;
  localparam int C_W        = 32;             // width of c_re / c_im
  localparam int Z_W        = C_W + 2;        // z after one step: |sq| + |c|, headroom
  localparam int OP_W       = FRAC_BITS + 3;  // multiplier operand, holds +/-2.0
  localparam int PROD_W     = 2 * OP_W;
  localparam int CLS_W      = 2;

  localparam logic [COUNT_BITS-1:0] MAX_ITER_RST = COUNT_BITS'(500);
  localparam logic [COUNT_BITS-1:0] CNT_FAST     = COUNT_BITS'(5);
  localparam logic [COUNT_BITS-1:0] CNT_MID      = COUNT_BITS'(15);

  localparam logic signed [Z_W-1:0] BOUND     = Z_W'(longint'(1) << (FRAC_BITS + 1));
  localparam logic signed [Z_W-1:0] NEG_BOUND = -BOUND;
  localparam logic signed [Z_W-1:0] FOUR      = Z_W'(longint'(1) << (FRAC_BITS + 2));

  typedef enum logic [CLS_W-1:0] {
    CLS_IN_SET = 2'd0,
    CLS_FAST   = 2'd1,
    CLS_MID    = 2'd2,
    CLS_SLOW   = 2'd3
  } color_t;

  typedef struct packed {
    logic load;    // take a new point, clear z and count
    logic mul;     // register the three products
    logic update;  // write back z, advance count
    logic finish;  // latch count and class
  } mec_cmd_t;

  typedef struct packed {
    logic lim_hit;  // count reached the limit
    logic out_box;  // |re| or |im| above 2
    logic escape;   // re^2 + im^2 above 4
  } mec_status_t;

endpackage

### hw/rtl/mandelbrot_escape_classifier.sv
// Top level of the Mandelbrot escape-time classifier: ties controller and
// datapath together. Uses mec_pkg, mec_ctrl and mec_datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------
//  input    | start / busy         | in_c_re, in_c_im (Q4.28 signed)
//  result   | out_valid (strobe)   | out_iter_count, out_color_class
//  config   | cfg_valid / cfg_ready| cfg_max_iter
//
// Each iteration first fills the three product registers, then makes the
// escape compare and the z update. The loop ends on the limit, on the +/-2
// box or on the magnitude test. Reset is synchronous, active low, and
// restores the limit to 500. The result strobe lasts one cycle and cannot be
// stalled; a new point may be taken during it.
module mandelbrot_escape_classifier (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [mec_pkg::C_W-1:0]      in_c_re,
  input  logic signed [mec_pkg::C_W-1:0]      in_c_im,
  output logic                                out_valid,
  output logic [mec_pkg::COUNT_BITS-1:0]      out_iter_count,
  output logic [mec_pkg::CLS_W-1:0]           out_color_class,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mec_pkg::COUNT_BITS-1:0]      cfg_max_iter
);

  mec_pkg::mec_cmd_t    cmd;
  mec_pkg::mec_status_t status;
  logic                 cfg_wr;

  assign cfg_ready = ~busy;
  assign cfg_wr    = cfg_valid & cfg_ready;

  mec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  mec_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .cfg_wr       (cfg_wr),
    .cfg_max_iter (cfg_max_iter),
    .in_c_re      (in_c_re),
    .in_c_im      (in_c_im),
    .iter_count   (out_iter_count),
    .color_class  (out_color_class)
  );

endmodule

### hw/rtl/mec_datapath.sv
// Datapath of the escape-time classifier: limit register, z registers,
// product registers, escape tests and result registers. Uses mec_pkg.
module mec_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mec_pkg::mec_cmd_t                  cmd,
  output mec_pkg::mec_status_t               status,
  input  logic                               cfg_wr,
  input  logic [mec_pkg::COUNT_BITS-1:0]     cfg_max_iter,
  input  logic signed [mec_pkg::C_W-1:0]     in_c_re,
  input  logic signed [mec_pkg::C_W-1:0]     in_c_im,
  output logic [mec_pkg::COUNT_BITS-1:0]     iter_count,
  output logic [mec_pkg::CLS_W-1:0]          color_class
);

  logic [mec_pkg::COUNT_BITS-1:0] max_iter_r;
  logic [mec_pkg::COUNT_BITS-1:0] cnt_r;
  logic [mec_pkg::COUNT_BITS-1:0] iter_r;
  mec_pkg::color_t                color_r;
  mec_pkg::color_t                color_nxt;
  logic signed [mec_pkg::C_W-1:0] c_re_r;
  logic signed [mec_pkg::C_W-1:0] c_im_r;
  logic signed [mec_pkg::Z_W-1:0] z_re_r;
  logic signed [mec_pkg::Z_W-1:0] z_im_r;
  logic signed [mec_pkg::Z_W-1:0] z_re_nxt;
  logic signed [mec_pkg::Z_W-1:0] z_im_nxt;
  logic signed [mec_pkg::Z_W-1:0] sq_re_r;
  logic signed [mec_pkg::Z_W-1:0] sq_im_r;
  logic signed [mec_pkg::Z_W-1:0] cross_r;
  logic signed [mec_pkg::Z_W-1:0] c_re_ext;
  logic signed [mec_pkg::Z_W-1:0] c_im_ext;
  logic signed [mec_pkg::OP_W-1:0] op_re;
  logic signed [mec_pkg::OP_W-1:0] op_im;
  logic signed [mec_pkg::PROD_W-1:0] prod_rr;
  logic signed [mec_pkg::PROD_W-1:0] prod_ii;
  logic signed [mec_pkg::PROD_W-1:0] prod_ri;
  logic signed [mec_pkg::PROD_W-1:0] shr_rr;
  logic signed [mec_pkg::PROD_W-1:0] shr_ii;
  logic signed [mec_pkg::PROD_W-1:0] shr_ri;
  logic signed [mec_pkg::Z_W-1:0] sq_sum;

  // Operands are only meaningful inside the +/-2 box; outside it the loop stops.
  assign op_re   = z_re_r[mec_pkg::OP_W-1:0];
  assign op_im   = z_im_r[mec_pkg::OP_W-1:0];
  assign prod_rr = op_re * op_re;
  assign prod_ii = op_im * op_im;
  assign prod_ri = op_re * op_im;
  // Floor division by the scale; the cross term carries the factor two.
  assign shr_rr  = prod_rr >>> mec_pkg::FRAC_BITS;
  assign shr_ii  = prod_ii >>> mec_pkg::FRAC_BITS;
  assign shr_ri  = prod_ri >>> (mec_pkg::FRAC_BITS - 1);

  assign c_re_ext = {{(mec_pkg::Z_W - mec_pkg::C_W){c_re_r[mec_pkg::C_W-1]}}, c_re_r};
  assign c_im_ext = {{(mec_pkg::Z_W - mec_pkg::C_W){c_im_r[mec_pkg::C_W-1]}}, c_im_r};
  assign sq_sum   = sq_re_r + sq_im_r;
  assign z_re_nxt = sq_re_r - sq_im_r + c_re_ext;
  assign z_im_nxt = cross_r + c_im_ext;

  assign status.lim_hit = (cnt_r >= max_iter_r);
  assign status.out_box = (z_re_r > mec_pkg::BOUND) || (z_re_r < mec_pkg::NEG_BOUND) ||
                          (z_im_r > mec_pkg::BOUND) || (z_im_r < mec_pkg::NEG_BOUND);
  assign status.escape  = (sq_sum > mec_pkg::FOUR);

  always_comb begin
    if (cnt_r == max_iter_r) begin
      color_nxt = mec_pkg::CLS_IN_SET;
    end else if (cnt_r < mec_pkg::CNT_FAST) begin
      color_nxt = mec_pkg::CLS_FAST;
    end else if (cnt_r < mec_pkg::CNT_MID) begin
      color_nxt = mec_pkg::CLS_MID;
    end else begin
      color_nxt = mec_pkg::CLS_SLOW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= mec_pkg::MAX_ITER_RST;
    end else if (cfg_wr) begin
      max_iter_r <= cfg_max_iter;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_re_r <= in_c_re;
      c_im_r <= in_c_im;
      z_re_r <= '0;
      z_im_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.update) begin
      z_re_r <= z_re_nxt;
      z_im_r <= z_im_nxt;
      cnt_r  <= cnt_r + 1'b1;
    end
    if (cmd.mul) begin
      sq_re_r <= shr_rr[mec_pkg::Z_W-1:0];
      sq_im_r <= shr_ii[mec_pkg::Z_W-1:0];
      cross_r <= shr_ri[mec_pkg::Z_W-1:0];
    end
    if (cmd.finish) begin
      iter_r  <= cnt_r;
      color_r <= color_nxt;
    end
  end

  assign iter_count  = iter_r;
  assign color_class = color_r;

`ifndef ASSERT_OFF
  a_cnt_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |-> (cnt_r <= max_iter_r))
    else $error("iteration count passed the limit");

  a_class_matches_limit: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.finish) |-> ((color_r == mec_pkg::CLS_IN_SET) == (iter_r == max_iter_r)))
    else $error("in-set class disagrees with count");
`endif

endmodule

### hw/rtl/mec_ctrl.sv
// Controller of the escape-time classifier: one-hot state machine that
// sequences the multiply and update steps. Uses mec_pkg.
module mec_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  mec_pkg::mec_status_t status,
  output mec_pkg::mec_cmd_t    cmd,
  output logic                 busy,
  output logic                 out_valid
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        // stop on the limit or when z has left the box
        if (status.lim_hit || status.out_box) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (status.escape) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.update = 1'b1;
          state_nxt  = ST_MUL;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = cmd.finish;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_start_enters_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (start && state_r == ST_IDLE) |=> (state_r == ST_MUL))
    else $error("accepted point did not enter the loop");

  a_finish_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (state_r != ST_IDLE))
    else $error("finish raised while idle");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");
`endif

endmodule

### test/tb.sv
// Testbench for the Mandelbrot escape-time classifier: drives points, predicts
// iteration count and color class, and checks every result strobe.
// Depends on mec_pkg and mandelbrot_escape_classifier.
`timescale 1ns / 1ps

module tb;
  import mec_pkg::*;

  localparam int ONE_Q = 1 << FRAC_BITS;          // 1.0 in Q4.28
  localparam longint CYCLE_LIMIT = 2_000_000;
  localparam int NUM_PHASES = 10;

  typedef struct {
    logic signed [C_W-1:0] re;
    logic signed [C_W-1:0] im;
  } point_t;

  typedef struct {
    logic [COUNT_BITS-1:0] count;
    color_t                cls;
  } escape_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [C_W-1:0] in_c_re = '0;
  logic signed [C_W-1:0] in_c_im = '0;
  logic out_valid;
  logic [COUNT_BITS-1:0] out_iter_count;
  logic [CLS_W-1:0] out_color_class;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [COUNT_BITS-1:0] cfg_max_iter = '0;

  point_t  point_q[$];
  escape_t escape_q[$];
  logic [COUNT_BITS-1:0] iter_limit = MAX_ITER_RST;
  int unsigned gap_pct = 0;
  int err_count = 0;
  longint cycles = 0;

  mandelbrot_escape_classifier dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_c_re         (in_c_re),
    .in_c_im         (in_c_im),
    .out_valid       (out_valid),
    .out_iter_count  (out_iter_count),
    .out_color_class (out_color_class),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_max_iter    (cfg_max_iter)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Iterate z = z*z + c in fixed point; products floor toward minus infinity.
  function automatic escape_t predict_escape(logic signed [C_W-1:0] c_re,
                                             logic signed [C_W-1:0] c_im,
                                             logic [COUNT_BITS-1:0] limit);
    longint two_q;
    longint four_q;
    longint cr;
    longint ci;
    longint zr;
    longint zi;
    longint sr;
    longint si;
    longint nim;
    int n;
    bit done;
    escape_t r;
    two_q = longint'(1) << (FRAC_BITS + 1);
    four_q = longint'(1) << (FRAC_BITS + 2);
    cr = c_re;
    ci = c_im;
    zr = 0;
    zi = 0;
    n = 0;
    done = 1'b0;
    while (!done && n < int'(limit)) begin
      if (zr > two_q || zr < -two_q || zi > two_q || zi < -two_q) begin
        done = 1'b1;
      end else begin
        sr = (zr * zr) >>> FRAC_BITS;
        si = (zi * zi) >>> FRAC_BITS;
        if (sr + si > four_q) begin
          done = 1'b1;
        end else begin
          nim = (((zr * 2) * zi) >>> FRAC_BITS) + ci;
          zr = sr - si + cr;
          zi = nim;
          n++;
        end
      end
    end
    r.count = COUNT_BITS'(n);
    if (n == int'(limit)) r.cls = CLS_IN_SET;
    else if (n < int'(CNT_FAST)) r.cls = CLS_FAST;
    else if (n < int'(CNT_MID)) r.cls = CLS_MID;
    else r.cls = CLS_SLOW;
    return r;
  endfunction

  function automatic logic signed [C_W-1:0] edge_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return 2 * ONE_Q;
      4: return -2 * ONE_Q;
      5: return 32'sd1;
      6: return -32'sd1;
      default: return 2 * ONE_Q + 1;
    endcase
  endfunction

  // Mostly points around the set, where counts spread over the full range.
  function automatic point_t random_point();
    point_t p;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      p.re = $urandom;
      p.im = $urandom;
    end else if (kind < 25) begin
      p.re = edge_value();
      p.im = edge_value();
    end else if (kind < 70) begin
      p.re = int'($urandom_range(0, 5 * ONE_Q / 2)) - 2 * ONE_Q;
      p.im = int'($urandom_range(0, 5 * ONE_Q / 2)) - 5 * ONE_Q / 4;
    end else begin
      // near the main cardioid boundary, where escape is slow
      p.re = int'($urandom_range(0, ONE_Q)) - 3 * ONE_Q / 4;
      p.im = int'($urandom_range(0, ONE_Q / 2)) + ONE_Q / 4;
      if ($urandom_range(0, 1)) p.im = -p.im;
    end
    return p;
  endfunction

  function automatic void add_point(int re, int im);
    point_t p;
    p.re = re;
    p.im = im;
    point_q.push_back(p);
  endfunction

  // Driver: present the head of the queue, hold it until the transfer.
  always @(posedge clk) begin : drive_points
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        escape_q.push_back(predict_escape(in_c_re, in_c_im, iter_limit));
        void'(point_q.pop_front());
      end
      if (start && busy) begin
        // hold the pending point
      end else if (point_q.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
        start   <= 1'b1;
        in_c_re <= point_q[0].re;
        in_c_im <= point_q[0].im;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobe must match the oldest prediction.
  always @(posedge clk) begin : check_results
    escape_t want;
    if (rst_n && out_valid) begin
      if (escape_q.size() == 0) begin
        $error("result with no point pending: iter_count %0d color_class %0d",
               out_iter_count, out_color_class);
        err_count++;
      end else begin
        want = escape_q.pop_front();
        if (out_iter_count !== want.count) begin
          $error("iter_count: expected %0d, got %0d", want.count, out_iter_count);
          err_count++;
        end
        if (out_color_class !== want.cls) begin
          $error("color_class: expected %0d, got %0d", want.cls, out_color_class);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Advance until every point is transferred and every result is back.
  task automatic drain();
    do @(posedge clk);
    while (point_q.size() != 0 || start || escape_q.size() != 0);
  endtask

  task automatic write_limit(logic [COUNT_BITS-1:0] value);
    cfg_valid    <= 1'b1;
    cfg_max_iter <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid  <= 1'b0;
    iter_limit = value;
  endtask

  initial begin : main_seq
    int unsigned phase_limit [NUM_PHASES];
    int unsigned phase_gap [NUM_PHASES];
    int unsigned phase_items [NUM_PHASES];
    phase_limit = '{0, 1, 5, 15, 1023, 30, 64, 20, 0, 500};
    phase_gap   = '{0, 72, 17, 0, 0, 72, 0, 17, 72, 0};
    phase_items = '{30, 50, 60, 60, 15, 250, 250, 200, 250, 20};
    phase_limit[8] = $urandom_range(2, 100);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed points at the reset limit
    add_point(0, 0);
    add_point(32'sh7fff_ffff, 32'sh7fff_ffff);
    add_point(32'sh8000_0000, 32'sh8000_0000);
    add_point(32'sh7fff_ffff, 0);
    add_point(0, 32'sh8000_0000);
    add_point(-2 * ONE_Q, 0);
    add_point(2 * ONE_Q, 0);
    add_point(0, 2 * ONE_Q);
    add_point(0, -2 * ONE_Q);
    add_point(ONE_Q / 4, 0);
    add_point(-ONE_Q, 0);
    add_point(0, ONE_Q);
    add_point(-3 * ONE_Q / 4, ONE_Q / 10);
    add_point(1, -1);
    add_point(ONE_Q / 2, ONE_Q / 2);
    add_point(-ONE_Q / 10, 13 * ONE_Q / 20);
    add_point(3 * ONE_Q / 10, 0);
    add_point(26 * ONE_Q / 100, 0);
    add_point(-5 * ONE_Q / 4, ONE_Q / 5);
    add_point(28 * ONE_Q / 100, 53 * ONE_Q / 100);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_limit(COUNT_BITS'(phase_limit[p]));
      gap_pct = phase_gap[p];
      repeat (phase_items[p]) point_q.push_back(random_point());
    end
    drain();
    repeat (2 * int'(iter_limit) + 8) @(posedge clk);

    if (escape_q.size() != 0) begin
      $error("iter_count: %0d results never arrived", escape_q.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
